// ===== rtl/core/tsf_pkg.sv =====
package tsf_pkg;

  localparam int SAMPLES       = 10;
  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;

  localparam int COORD_W    = 12;
  localparam int SUM_W      = 18;
  localparam int CNT_W      = 6;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int DIVIDEND_W = 24;
  localparam int DIVISOR_W  = 12;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

  localparam logic [COORD_W-1:0]   COORD_MAX   = '1;
  localparam logic [CNT_W-1:0]     SAMPLES_C   = CNT_W'(SAMPLES);
  localparam logic [SUM_W-1:0]     AVG_DIVISOR = SUM_W'(SAMPLES - 2);
  localparam logic [COORD_W-1:0]   WIDTH_C     = COORD_W'(SCREEN_WIDTH);
  localparam logic [COORD_W-1:0]   HEIGHT_C    = COORD_W'(SCREEN_HEIGHT);
  localparam logic [THR_W-1:0]     THRESHOLD_RST = THR_W'(8);
  localparam logic [COORD_W-1:0]   LIMIT_RST     = COORD_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CALIBRATING    = 3'd0,
    CFG_LEFT_END_X     = 3'd1,
    CFG_RIGHT_END_X    = 3'd2,
    CFG_TOP_END_Y      = 3'd3,
    CFG_BOTTOM_END_Y   = 3'd4,
    CFG_MOVE_THRESHOLD = 3'd5,
    CFG_MOVE_LIMIT     = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_PRESS       = 2'd0,
    EV_MOVE        = 2'd1,
    EV_RELEASE     = 2'd2,
    EV_CAL_RELEASE = 2'd3
  } event_kind_t;

  typedef enum logic {
    CMD_POINT   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SUM_W-1:0]   trim_x;
    logic [SUM_W-1:0]   trim_y;
  } cmd_t;

  typedef struct packed {
    logic  push;
    cmd_t  cmd;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    cmd_t  cmd;
  } q_rd_t;

  typedef struct packed {
    logic                  calibrating;
    logic [COORD_W-1:0]    left_end_x;
    logic [COORD_W-1:0]    right_end_x;
    logic [COORD_W-1:0]    top_end_y;
    logic [COORD_W-1:0]    bottom_end_y;
    logic [THR_W-1:0]      move_threshold;
    logic [COORD_W-1:0]    move_limit;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic [DIVIDEND_W-1:0]  dividend;
    logic [DIVISOR_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [DIVIDEND_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/touch_sample_filter_and_event_fsm_top.sv =====
// Touch sample filter with pen event generation.
// Input channel in_*: in_tuser = 0 carries a raw X/Y pair taken while the pen is
// pressed, in_tuser = 1 is a poll tick with the pen released. Every SAMPLES pairs
// make one filtered point (min and max of each axis dropped, rest averaged), which
// is scaled to the screen unless calibrating and fed to a press/move/release FSM.
// Output channel out_*: one event per transfer, out_tuser = kind, out_tdata = X, Y.
// Configuration: cfg_we writes register cfg_idx with cfg_wdata in the same cycle;
// write only while no item is in flight.
// An input item is taken whenever the two-entry command queue between
// the sample collector and the event engine has room. Each scaled axis takes a
// multiply and a 24-step radix-2 division on one shared divider, and the engine
// finishes one point before it takes the next from the queue. An axis with equal
// ends or a value below its range skips its division; while calibrating a point
// is not scaled and emits nothing. A release tick with the pen down goes through
// the queue and the S_EMIT state to the output register.
// Reset (rst_n low, synchronous) clears the accumulators, the queue, the pen state
// and the output register, and loads the register defaults.
// When the receiver stalls the event waits in the output register, the engine
// holds before its next emit, and once the queue fills in_tready drops.
module touch_sample_filter_and_event_fsm_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [2*tsf_pkg::COORD_W-1:0]    in_tdata,   // raw_x [11:0], raw_y [23:12]
  input  logic                             in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [2*tsf_pkg::COORD_W-1:0]    out_tdata,  // pos_x [11:0], pos_y [23:12]
  output logic [1:0]                       out_tuser,  // event_kind
  input  logic                             cfg_we,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tsf_pkg::*;

  cfg_t     cfg_r;
  q_wr_t    q_wr;
  q_rd_t    q_rd;
  logic     q_full, q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calibrating    <= 1'b0;
      cfg_r.left_end_x     <= '0;
      cfg_r.right_end_x    <= '0;
      cfg_r.top_end_y      <= '0;
      cfg_r.bottom_end_y   <= '0;
      cfg_r.move_threshold <= THRESHOLD_RST;
      cfg_r.move_limit     <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CALIBRATING:    cfg_r.calibrating    <= cfg_wdata[0];
        CFG_LEFT_END_X:     cfg_r.left_end_x     <= cfg_wdata[COORD_W-1:0];
        CFG_RIGHT_END_X:    cfg_r.right_end_x    <= cfg_wdata[COORD_W-1:0];
        CFG_TOP_END_Y:      cfg_r.top_end_y      <= cfg_wdata[COORD_W-1:0];
        CFG_BOTTOM_END_Y:   cfg_r.bottom_end_y   <= cfg_wdata[COORD_W-1:0];
        CFG_MOVE_THRESHOLD: cfg_r.move_threshold <= cfg_wdata[THR_W-1:0];
        CFG_MOVE_LIMIT:     cfg_r.move_limit     <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  tsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_wr      (q_wr)
  );

  tsf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  tsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_rd       (q_rd),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !(in_tvalid && in_tready))
    else $error("command queue written while full");

  a_cal_release_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && cfg_r.calibrating) |-> (out_tuser == EV_CAL_RELEASE))
    else $error("press or move reported while calibrating");

  a_screen_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !cfg_r.calibrating && (out_tuser == EV_PRESS || out_tuser == EV_MOVE))
    |-> (out_tdata[COORD_W-1:0] < WIDTH_C && out_tdata[2*COORD_W-1:COORD_W] < HEIGHT_C))
    else $error("scaled position outside the screen");

endmodule

// ===== rtl/core/tsf_front.sv =====
module tsf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [2*tsf_pkg::COORD_W-1:0]   in_tdata,   // raw_x, raw_y
  input  logic                            in_tuser,   // opcode
  input  logic                            q_full,
  output tsf_pkg::q_wr_t                  q_wr
);
  import tsf_pkg::*;

  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [SUM_W-1:0]   sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0]   sum_y_r, sum_y_nxt;
  logic [COORD_W-1:0] min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic [COORD_W-1:0] min_y_r, min_y_nxt, max_y_r, max_y_nxt;

  logic [COORD_W-1:0] rx, ry;
  logic               accept, is_release, set_done;

  assign rx         = in_tdata[COORD_W-1:0];
  assign ry         = in_tdata[2*COORD_W-1:COORD_W];
  assign in_tready  = !q_full;
  assign accept     = in_tvalid && in_tready;
  assign is_release = (cmd_kind_t'(in_tuser) == CMD_RELEASE);

  always_comb begin
    cnt_nxt   = cnt_r + CNT_W'(1);
    sum_x_nxt = sum_x_r + SUM_W'(rx);
    sum_y_nxt = sum_y_r + SUM_W'(ry);
    min_x_nxt = (rx < min_x_r) ? rx : min_x_r;
    max_x_nxt = (rx > max_x_r) ? rx : max_x_r;
    min_y_nxt = (ry < min_y_r) ? ry : min_y_r;
    max_y_nxt = (ry > max_y_r) ? ry : max_y_r;
    set_done  = (cnt_nxt == SAMPLES_C);

    q_wr.push        = accept && (is_release || set_done);
    q_wr.cmd.kind    = is_release ? CMD_RELEASE : CMD_POINT;
    q_wr.cmd.trim_x  = sum_x_nxt - SUM_W'(min_x_nxt) - SUM_W'(max_x_nxt);
    q_wr.cmd.trim_y  = sum_y_nxt - SUM_W'(min_y_nxt) - SUM_W'(max_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && (is_release || set_done))) begin
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      min_x_r <= COORD_MAX;
      max_x_r <= '0;
      min_y_r <= COORD_MAX;
      max_y_r <= '0;
    end else if (accept) begin
      cnt_r   <= cnt_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
    end
  end

endmodule

// ===== rtl/core/tsf_fifo.sv =====
module tsf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  tsf_pkg::q_wr_t  wr,
  output logic            full,
  output tsf_pkg::q_rd_t  rd,
  input  logic            pop
);
  import tsf_pkg::*;

  cmd_t                   slots_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CNT_W-1:0] count_r;
  logic                   do_push, do_pop;

  assign full     = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign rd.valid = (count_r != '0);
  assign rd.cmd   = slots_r[rd_ptr_r];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/tsf_div.sv =====
module tsf_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tsf_pkg::div_req_t  req,
  output tsf_pkg::div_rsp_t  rsp
);
  import tsf_pkg::*;

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  // restoring radix-2: dividend bits shift out of the top of quo_r as quotient bits enter
  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = {1'b0, trial} - {2'b00, divisor_r};
    ge      = !diff[DIVISOR_W+1];
    rem_nxt = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[DIVIDEND_W-2:0], ge};
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        cnt_r     <= '0;
        rem_r     <= '0;
        quo_r     <= req.dividend;
        divisor_r <= req.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/tsf_back.sv =====
module tsf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tsf_pkg::cfg_t                  cfg,
  input  tsf_pkg::q_rd_t                 q_rd,
  output logic                           q_pop,
  output tsf_pkg::div_req_t              div_req,
  input  tsf_pkg::div_rsp_t              div_rsp,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [2*tsf_pkg::COORD_W-1:0]  out_tdata,   // pos_x, pos_y
  output logic [1:0]                     out_tuser    // event_kind
);
  import tsf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_SCALE_GO, S_SCALE_WAIT, S_EVENT, S_EMIT
  } state_t;

  state_t                state_r;
  logic                  ax_r;
  logic [COORD_W-1:0]    val_x_r, val_y_r;
  logic [COORD_W-1:0]    num_r, den_r;
  logic [DIVIDEND_W-1:0] prod_r;
  logic                  pen_r;
  logic [COORD_W-1:0]    last_x_r, last_y_r;
  event_kind_t           kind_r;
  logic                  out_valid_r;
  event_kind_t           out_kind_r;
  logic [COORD_W-1:0]    out_x_r, out_y_r;

  logic [SUM_W-1:0]   avg_x, avg_y;
  logic [COORD_W-1:0] cur_v, lo_end, hi_end, size;
  logic               hi_gt, hi_lt, num_neg;
  logic [COORD_W:0]   num_s;
  logic [COORD_W-1:0] den, clamp_v, q_clamp;
  logic [COORD_W-1:0] adx, ady;
  logic               dead, jump, slot_free;

  always_comb begin
    avg_x   = q_rd.cmd.trim_x / AVG_DIVISOR;
    avg_y   = q_rd.cmd.trim_y / AVG_DIVISOR;
    cur_v   = ax_r ? val_y_r : val_x_r;
    lo_end  = ax_r ? cfg.top_end_y : cfg.left_end_x;
    hi_end  = ax_r ? cfg.bottom_end_y : cfg.right_end_x;
    size    = ax_r ? HEIGHT_C : WIDTH_C;
    hi_gt   = hi_end > lo_end;
    hi_lt   = hi_end < lo_end;
    num_s   = hi_gt ? ({1'b0, cur_v} - {1'b0, lo_end}) : ({1'b0, lo_end} - {1'b0, cur_v});
    num_neg = num_s[COORD_W];
    den     = hi_gt ? (hi_end - lo_end) : (lo_end - hi_end);
    clamp_v = (cur_v >= size) ? (size - COORD_W'(1)) : cur_v;
    q_clamp = (div_rsp.quotient >= DIVIDEND_W'(size)) ? (size - COORD_W'(1))
                                                      : div_rsp.quotient[COORD_W-1:0];

    adx  = (val_x_r >= last_x_r) ? (val_x_r - last_x_r) : (last_x_r - val_x_r);
    ady  = (val_y_r >= last_y_r) ? (val_y_r - last_y_r) : (last_y_r - val_y_r);
    dead = (adx < COORD_W'(cfg.move_threshold)) && (ady < COORD_W'(cfg.move_threshold));
    jump = (adx > cfg.move_limit) || (ady > cfg.move_limit);

    slot_free = !out_valid_r || out_tready;
    q_pop     = (state_r == S_IDLE) && q_rd.valid;

    div_req.start    = (state_r == S_SCALE_GO);
    div_req.dividend = prod_r;
    div_req.divisor  = den_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= 1'b0;
      pen_r       <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_rd.valid) begin
            if (q_rd.cmd.kind == CMD_RELEASE) begin
              if (pen_r) begin
                pen_r   <= 1'b0;
                kind_r  <= cfg.calibrating ? EV_CAL_RELEASE : EV_RELEASE;
                state_r <= S_EMIT;
              end
            end else begin
              // average both axes straight off the queue head
              val_x_r <= avg_x[COORD_W-1:0];
              val_y_r <= avg_y[COORD_W-1:0];
              ax_r    <= 1'b0;
              state_r <= cfg.calibrating ? S_EVENT : S_PREP;
            end
          end
        end
        S_PREP: begin
          if (hi_gt || hi_lt) begin
            if (num_neg) begin
              if (ax_r) val_y_r <= '0; else val_x_r <= '0;
              ax_r    <= 1'b1;
              state_r <= ax_r ? S_EVENT : S_PREP;
            end else begin
              num_r   <= num_s[COORD_W-1:0];
              den_r   <= den;
              state_r <= S_MUL;
            end
          end else begin
            // equal ends: clamp only
            if (ax_r) val_y_r <= clamp_v; else val_x_r <= clamp_v;
            ax_r    <= 1'b1;
            state_r <= ax_r ? S_EVENT : S_PREP;
          end
        end
        S_MUL: begin
          prod_r  <= DIVIDEND_W'(num_r) * DIVIDEND_W'(size);
          state_r <= S_SCALE_GO;
        end
        S_SCALE_GO: begin
          state_r <= S_SCALE_WAIT;
        end
        S_SCALE_WAIT: begin
          if (div_rsp.done) begin
            if (ax_r) val_y_r <= q_clamp; else val_x_r <= q_clamp;
            ax_r    <= 1'b1;
            state_r <= ax_r ? S_EVENT : S_PREP;
          end
        end
        S_EVENT: begin
          if (!pen_r) begin
            pen_r    <= 1'b1;
            last_x_r <= val_x_r;
            last_y_r <= val_y_r;
            kind_r   <= EV_PRESS;
            state_r  <= cfg.calibrating ? S_IDLE : S_EMIT;
          end else if (dead || jump) begin
            state_r <= S_IDLE;
          end else begin
            last_x_r <= val_x_r;
            last_y_r <= val_y_r;
            kind_r   <= EV_MOVE;
            state_r  <= cfg.calibrating ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            out_x_r     <= last_x_r;
            out_y_r     <= last_y_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/touch_sample_filter_and_event_fsm_top_tb.sv =====
`timescale 1ns / 1ps

module touch_sample_filter_and_event_fsm_top_tb;
  import tsf_pkg::*;

  localparam int  CLK_PERIOD    = 12;
  localparam int  RESET_CYCLES  = 6;
  localparam int  HOLD_CYCLES   = 2000;
  localparam int  DRAIN_CYCLES  = 400;
  localparam int  FINAL_WAIT    = 20000;
  localparam real RUN_LIMIT_NS  = 12.0 * 600000.0;

  typedef struct {
    event_kind_t         kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
  } pen_event_t;

  // Tracks pen state and filtered points, and holds the events still to come out.
  class touch_event_scoreboard;
    logic                calibrating;
    logic [COORD_W-1:0]  left_x, right_x, top_y, bottom_y;
    logic [THR_W-1:0]    threshold;
    logic [COORD_W-1:0]  limit;

    logic                pen_down;
    logic [COORD_W-1:0]  last_x, last_y;
    int                  count, sum_x, sum_y, min_x, max_x, min_y, max_y;

    pen_event_t          expected_events[$];
    int                  mismatches;
    int                  events_checked;
    int                  points_filtered;
    int                  kind_seen[4];

    function new();
      calibrating = 1'b0;
      left_x      = '0;
      right_x     = '0;
      top_y       = '0;
      bottom_y    = '0;
      threshold   = THRESHOLD_RST;
      limit       = LIMIT_RST;
      pen_down    = 1'b0;
      last_x      = '0;
      last_y      = '0;
      mismatches  = 0;
      events_checked  = 0;
      points_filtered = 0;
      clear_set();
    endfunction

    function void clear_set();
      count = 0;
      sum_x = 0;
      sum_y = 0;
      min_x = 4095;
      max_x = 0;
      min_y = 4095;
      max_y = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CALIBRATING:    calibrating = val[0];
        CFG_LEFT_END_X:     left_x      = val;
        CFG_RIGHT_END_X:    right_x     = val;
        CFG_TOP_END_Y:      top_y       = val;
        CFG_BOTTOM_END_Y:   bottom_y    = val;
        CFG_MOVE_THRESHOLD: threshold   = val[THR_W-1:0];
        CFG_MOVE_LIMIT:     limit       = val;
        default: ;
      endcase
    endfunction

    // Map a filtered raw value between two ends onto 0 .. size-1.
    function int to_screen(int v, int lo_end, int hi_end, int size);
      int num, den, q;
      if (hi_end > lo_end) begin
        num = v - lo_end;
        den = hi_end - lo_end;
      end else if (hi_end < lo_end) begin
        num = lo_end - v;
        den = lo_end - hi_end;
      end else begin
        return (v >= size) ? size - 1 : v;
      end
      if (num < 0) return 0;
      q = (num * size) / den;
      return (q >= size) ? size - 1 : q;
    endfunction

    function void push_event(event_kind_t kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pen_event_t ev;
      ev.kind = kind;
      ev.x    = x;
      ev.y    = y;
      expected_events.push_back(ev);
    endfunction

    function void note_input(cmd_kind_t op, logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry);
      int px, py, dx, dy, t, l;
      if (op == CMD_RELEASE) begin
        clear_set();
        if (!pen_down) return;
        pen_down = 1'b0;
        push_event(calibrating ? EV_CAL_RELEASE : EV_RELEASE, last_x, last_y);
        return;
      end
      sum_x += int'(rx);
      sum_y += int'(ry);
      if (int'(rx) < min_x) min_x = int'(rx);
      if (int'(rx) > max_x) max_x = int'(rx);
      if (int'(ry) < min_y) min_y = int'(ry);
      if (int'(ry) > max_y) max_y = int'(ry);
      count++;
      if (count < SAMPLES) return;

      points_filtered++;
      px = (sum_x - min_x - max_x) / (SAMPLES - 2);
      py = (sum_y - min_y - max_y) / (SAMPLES - 2);
      clear_set();
      if (!calibrating) begin
        px = to_screen(px, int'(left_x), int'(right_x), SCREEN_WIDTH);
        py = to_screen(py, int'(top_y), int'(bottom_y), SCREEN_HEIGHT);
      end
      px &= 32'hFFF;
      py &= 32'hFFF;

      if (!pen_down) begin
        pen_down = 1'b1;
        last_x   = COORD_W'(px);
        last_y   = COORD_W'(py);
        if (!calibrating) push_event(EV_PRESS, COORD_W'(px), COORD_W'(py));
        return;
      end

      dx = px - int'(last_x);
      dy = py - int'(last_y);
      t  = int'(threshold);
      l  = int'(limit);
      // drop moves inside the dead band, then jumps beyond the limit
      if (dx > -t && dx < t && dy > -t && dy < t) return;
      if (dx < -l || dx > l || dy < -l || dy > l) return;
      last_x = COORD_W'(px);
      last_y = COORD_W'(py);
      if (!calibrating) push_event(EV_MOVE, COORD_W'(px), COORD_W'(py));
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pen_event_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event kind %0d at (%0d,%0d)", kind, x, y));
        return;
      end
      want = expected_events.pop_front();
      events_checked++;
      kind_seen[kind]++;
      if (kind !== want.kind)
        report($sformatf("event kind %0d, want %s", kind, want.kind.name()));
      if (x !== want.x)
        report($sformatf("%s pos_x %0d, want %0d", want.kind.name(), x, want.x));
      if (y !== want.y)
        report($sformatf("%s pos_y %0d, want %0d", want.kind.name(), y, want.y));
    endtask

    function int pending();
      return expected_events.size();
    endfunction

    task flush_leftovers();
      pen_event_t ev;
      while (expected_events.size() != 0) begin
        ev = expected_events.pop_front();
        report($sformatf("missing %s at (%0d,%0d)", ev.kind.name(), ev.x, ev.y));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [2*COORD_W-1:0]    in_tdata;    // raw_x [11:0], raw_y [23:12]
  logic                    in_tuser;    // opcode
  logic                    out_tvalid;
  logic                    out_tready;
  logic [2*COORD_W-1:0]    out_tdata;   // pos_x [11:0], pos_y [23:12]
  logic [1:0]              out_tuser;   // event_kind
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  touch_event_scoreboard sb;
  int  items_sent;
  int  settings_used;
  bit  in_gaps;
  bit  out_stalls;
  bit  hold_off_req;

  touch_sample_filter_and_event_fsm_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** touch_sample_filter_and_event_fsm_top: FAILED **");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (out_stalls && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[COORD_W-1:0], out_tdata[2*COORD_W-1:COORD_W]);
  end

  function automatic logic [COORD_W-1:0] clip12(int v);
    if (v < 0) return '0;
    if (v > 4095) return COORD_MAX;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] rand12();
    return COORD_W'($urandom_range(0, 4095));
  endfunction

  task automatic send_item(input cmd_kind_t op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, x, y);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_settings(input bit cal, input int lx, input int rx, input int ty,
                                input int by, input int thr, input int lim);
    write_reg(CFG_CALIBRATING, CFG_DATA_W'(cal));
    write_reg(CFG_LEFT_END_X, CFG_DATA_W'(lx));
    write_reg(CFG_RIGHT_END_X, CFG_DATA_W'(rx));
    write_reg(CFG_TOP_END_Y, CFG_DATA_W'(ty));
    write_reg(CFG_BOTTOM_END_Y, CFG_DATA_W'(by));
    write_reg(CFG_MOVE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_MOVE_LIMIT, CFG_DATA_W'(lim));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Wait for every expected event, then let a point still in the engine finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One full sample set around a centre: small jitter and one wild reading.
  task automatic send_point(input int cx, input int cy);
    int wild;
    logic [COORD_W-1:0] x, y;
    wild = $urandom_range(0, SAMPLES - 1);
    for (int i = 0; i < SAMPLES; i++) begin
      if (i == wild) begin
        x = rand12();
        y = rand12();
      end else begin
        x = clip12(cx + int'($urandom_range(0, 40)) - 20);
        y = clip12(cy + int'($urandom_range(0, 40)) - 20);
      end
      send_item(CMD_POINT, x, y);
    end
  endtask

  task automatic touch_session();
    int cx, cy, d, npoints;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    npoints = $urandom_range(1, 5);
    for (int p = 0; p < npoints; p++) begin
      send_point(cx, cy);
      case ($urandom_range(0, 4))
        0:       d = 15;
        1, 2:    d = 250;
        3:       d = 1200;
        default: d = 0;
      endcase
      if (d == 0) begin
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
      end else begin
        cx = clip12(cx + int'($urandom_range(0, 2 * d)) - d);
        cy = clip12(cy + int'($urandom_range(0, 2 * d)) - d);
      end
    end
    send_item(CMD_RELEASE, rand12(), rand12());
  endtask

  task automatic run_phase(input int n_items, input bit quiet);
    int target, r, n;
    target = items_sent + n_items;
    while (items_sent < target) begin
      in_gaps    = !quiet && ($urandom_range(0, 3) != 0);
      out_stalls = !quiet && ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        touch_session();
      end else if (r < 87) begin
        send_item(CMD_RELEASE, rand12(), rand12());
      end else if (r < 94) begin
        // broken set: a few readings, then the pen lifts
        n = $urandom_range(1, SAMPLES - 1);
        repeat (n) send_item(CMD_POINT, rand12(), rand12());
        send_item(CMD_RELEASE, rand12(), rand12());
      end else begin
        repeat (SAMPLES)
          send_item(CMD_POINT, rand12(), rand12());
      end
    end
    settle();
  endtask

  initial begin
    sb            = new();
    items_sent    = 0;
    settings_used = 0;
    in_gaps       = 1'b0;
    out_stalls    = 1'b0;
    hold_off_req  = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: X runs forward, Y runs backward.
    apply_settings(1'b0, 1000, 3000, 3500, 500, 8, 100);
    send_item(CMD_RELEASE, COORD_MAX, COORD_MAX);        // pen already up
    // field extremes land on min/max and are trimmed; the rest falls below range
    send_item(CMD_POINT, 12'd0, COORD_MAX);
    send_item(CMD_POINT, COORD_MAX, 12'd0);
    repeat (SAMPLES - 2) send_item(CMD_POINT, 12'd500, 12'd3900);
    // partial set, then release: readings discarded, release at last position
    repeat (4) send_item(CMD_POINT, 12'd2000, 12'd2000);
    send_item(CMD_RELEASE, 12'd0, 12'd0);
    // above range on both axes
    repeat (SAMPLES) send_item(CMD_POINT, 12'd3500, 12'd100);
    send_item(CMD_RELEASE, 12'd0, 12'd0);
    settle();

    apply_settings(1'b0, 200, 3900, 3800, 300, 8, 100);
    hold_off_req = 1'b1;
    run_phase(200, 1'b0);

    // equal ends: clamp only; zero dead band, widest limit
    apply_settings(1'b0, 0, 0, 4095, 4095, 0, 4095);
    run_phase(200, 1'b0);

    apply_settings(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095), 255, 0);
    run_phase(180, 1'b0);

    apply_settings(1'b0, 4095, 0, 0, 4095, 1, 20);
    run_phase(200, 1'b0);

    apply_settings(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 255), $urandom_range(0, 4095));
    run_phase(170, 1'b0);

    apply_settings(1'b1, 0, 4095, 4095, 0, 4, 4095);
    run_phase(150, 1'b1);

    for (int i = 0; i < FINAL_WAIT && sb.pending() != 0; i++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_leftovers();

    $display("Run covered %0d input transfers, %0d filtered points, %0d register settings.",
             items_sent, sb.points_filtered, settings_used);
    $display("Events checked: %0d (press %0d, move %0d, release %0d, calibration %0d).",
             sb.events_checked, sb.kind_seen[EV_PRESS], sb.kind_seen[EV_MOVE],
             sb.kind_seen[EV_RELEASE], sb.kind_seen[EV_CAL_RELEASE]);
    if (sb.mismatches == 0) begin
      $display("** touch_sample_filter_and_event_fsm_top: PASSED **");
    end else begin
      $display("** touch_sample_filter_and_event_fsm_top: FAILED **");
    end
    $finish;
  end

endmodule
